// ===== sv/pixel_contrast_tint_adjust_macros.svh =====
// Assertion macros used by the pixel contrast/tint adjust flow control.
`ifndef PIXEL_CONTRAST_TINT_ADJUST_MACROS_SVH
`define PIXEL_CONTRAST_TINT_ADJUST_MACROS_SVH

// Same-cycle implication, checked on clk_i, off while rst_ni is low.
`define PCTA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk_i, off while rst_ni is low.
`define PCTA_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/pcta_pkg.sv =====
// Types, constants and codes of the pixel contrast/tint adjust block.
package pcta_pkg;

  localparam int CH_W       = 8;
  localparam int PCT_W      = 7;
  localparam int SEL_W      = 3;
  localparam int K_W        = 8;
  localparam int N_W        = 15;
  localparam int M_W        = 16;
  localparam int RECIP_W    = 13;
  localparam int RECIP_SHIFT = 19;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  localparam int QUOT_W     = 8;
  localparam int DIV_STEPS  = 2;
  localparam int DIV_STAGES = QUOT_W / DIV_STEPS;
  localparam int PIPE_DEPTH = DIV_STAGES + 2;
  localparam int OUT_STAGE  = PIPE_DEPTH - 1;

  localparam logic [K_W-1:0]     K_BASE      = 8'd100;
  localparam logic [CH_W-1:0]    CH_MID      = 8'd127;
  localparam logic [CH_W-1:0]    CH_MAX      = 8'd255;
  localparam logic [CH_W-1:0]    POSTER_MASK = 8'hC0;
  localparam logic [M_W-1:0]     SAT_HI_LIM  = 16'd25500;
  localparam logic [M_W-1:0]     SAT_LO_LIM  = 16'd12700;
  // floor(x / 100) == (x * 5243) >> 19 for every x up to 25500; larger products
  // are saturated before the quotient is used
  localparam logic [RECIP_W-1:0] RECIP_100   = 13'd5243;

  typedef enum logic [SEL_W-1:0] {
    FILT_RAISE      = 3'd0,
    FILT_LOWER      = 3'd1,
    FILT_TINT_BLUE  = 3'd2,
    FILT_TINT_GREEN = 3'd3,
    FILT_TINT_RED   = 3'd4,
    FILT_POSTER     = 3'd5
  } filter_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FILTER  = 2'd0,
    CFG_PERCENT = 2'd1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    OP_PASS   = 3'd0,
    OP_RAISE  = 3'd1,
    OP_LOWER  = 3'd2,
    OP_TINT   = 3'd3,
    OP_POSTER = 3'd4
  } chan_op_e;

  typedef struct packed {
    logic [PIPE_DEPTH-1:0] load;
  } stage_ctl_t;

endpackage

// ===== sv/pcta_chan.sv =====
// Per-channel datapath: products, pipelined restoring divider, filter select.
module pcta_chan import pcta_pkg::*; (
  input  logic            clk_i,
  input  stage_ctl_t      ctl_i,
  input  chan_op_e        op_i,
  input  logic [K_W-1:0]  k_i,
  input  logic [CH_W-1:0] pix_i,
  output logic [CH_W-1:0] pix_o
);

  logic [CH_W-1:0]   v_q    [DIV_STAGES+1];
  logic [N_W-1:0]    rem_q  [DIV_STAGES];
  logic [QUOT_W-1:0] quot_q [DIV_STAGES+1];
  logic [M_W-1:0]    m_q;
  logic [CH_W-1:0]   qm_q    [1:DIV_STAGES];
  logic              hi_q    [1:DIV_STAGES];
  logic              lo_q    [1:DIV_STAGES];
  logic              below_q [1:DIV_STAGES];
  logic [CH_W-1:0]   res_q, res_d;

  logic [M_W+RECIP_W-1:0] scaled;
  logic [N_W-1:0]         k_mid;

  // front stage: v*100 feeds the divider, v*k the scaled-product path
  always_ff @(posedge clk_i) begin
    if (ctl_i.load[0]) begin
      v_q[0]    <= pix_i;
      rem_q[0]  <= N_W'(pix_i) * N_W'(K_BASE);
      quot_q[0] <= '0;
      m_q       <= M_W'(pix_i) * M_W'(k_i);
    end
  end

  assign scaled = (M_W+RECIP_W)'(m_q) * (M_W+RECIP_W)'(RECIP_100);
  assign k_mid  = N_W'(k_i) * N_W'(CH_MID);

  for (genvar s = 1; s <= DIV_STAGES; s++) begin : g_div
    logic [N_W-1:0]    rem_d;
    logic [QUOT_W-1:0] quot_d;

    always_comb begin
      logic [N_W-1:0] dvs;
      rem_d  = rem_q[s-1];
      quot_d = quot_q[s-1];
      for (int t = 0; t < DIV_STEPS; t++) begin
        dvs = N_W'(k_i) << (QUOT_W - 1 - (s - 1) * DIV_STEPS - t);
        if (rem_d >= dvs) begin
          rem_d = rem_d - dvs;
          quot_d[QUOT_W - 1 - (s - 1) * DIV_STEPS - t] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (ctl_i.load[s]) begin
        quot_q[s] <= quot_d;
        v_q[s]    <= v_q[s-1];
      end
    end

    if (s < DIV_STAGES) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (ctl_i.load[s]) begin
          rem_q[s] <= rem_d;
        end
      end
    end

    if (s == 1) begin : g_first
      always_ff @(posedge clk_i) begin
        if (ctl_i.load[s]) begin
          qm_q[s]    <= scaled[RECIP_SHIFT +: CH_W];
          hi_q[s]    <= (m_q > SAT_HI_LIM);
          lo_q[s]    <= (m_q > SAT_LO_LIM);
          below_q[s] <= (rem_q[0] < k_mid);
        end
      end
    end else begin : g_carry
      always_ff @(posedge clk_i) begin
        if (ctl_i.load[s]) begin
          qm_q[s]    <= qm_q[s-1];
          hi_q[s]    <= hi_q[s-1];
          lo_q[s]    <= lo_q[s-1];
          below_q[s] <= below_q[s-1];
        end
      end
    end
  end

  // pick the filtered value for this channel
  always_comb begin
    logic [CH_W-1:0] v;
    v = v_q[DIV_STAGES];
    unique case (op_i)
      OP_RAISE: begin
        if (v > CH_MID) begin
          res_d = hi_q[DIV_STAGES] ? CH_MAX : qm_q[DIV_STAGES];
        end else begin
          res_d = quot_q[DIV_STAGES];
        end
      end
      OP_LOWER: begin
        if (v > CH_MID) begin
          res_d = below_q[DIV_STAGES] ? CH_MID : quot_q[DIV_STAGES];
        end else begin
          res_d = lo_q[DIV_STAGES] ? CH_MID : qm_q[DIV_STAGES];
        end
      end
      OP_TINT:   res_d = hi_q[DIV_STAGES] ? CH_MAX : qm_q[DIV_STAGES];
      OP_POSTER: res_d = (v == CH_MAX) ? CH_MAX : (v & POSTER_MASK);
      OP_PASS:   res_d = v;
      default:   res_d = v;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load[OUT_STAGE]) begin
      res_q <= res_d;
    end
  end

  assign pix_o = res_q;

endmodule

// ===== sv/pcta_flow.sv =====
// Pipeline flow control: per-stage valid bits, load enables, last-pixel flag.
`include "pixel_contrast_tint_adjust_macros.svh"

module pcta_flow import pcta_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       last_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       last_o,
  output stage_ctl_t ctl_o
);

  logic [PIPE_DEPTH-1:0] valid_q, valid_d;
  logic [PIPE_DEPTH-1:0] last_q;
  logic [PIPE_DEPTH-1:0] load;
  logic                  in_acc, out_acc;

  // a stage loads when it is empty or its content moves on
  always_comb begin
    load[OUT_STAGE] = !valid_q[OUT_STAGE] || out_ready_i;
    for (int s = OUT_STAGE - 1; s >= 0; s--) begin
      load[s] = !valid_q[s] || load[s+1];
    end
  end

  always_comb begin
    logic [PIPE_DEPTH-1:0] shifted;
    shifted = {valid_q[PIPE_DEPTH-2:0], in_valid_i};
    for (int s = 0; s < PIPE_DEPTH; s++) begin
      valid_d[s] = load[s] ? shifted[s] : valid_q[s];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    logic [PIPE_DEPTH-1:0] last_in;
    last_in = {last_q[PIPE_DEPTH-2:0], last_i};
    for (int s = 0; s < PIPE_DEPTH; s++) begin
      if (load[s]) begin
        last_q[s] <= last_in[s];
      end
    end
  end

  assign in_ready_o  = load[0];
  assign out_valid_o = valid_q[OUT_STAGE];
  assign last_o      = last_q[OUT_STAGE];
  assign ctl_o.load  = load;
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_acc     = out_valid_o && out_ready_i;

  // a stalled stage keeps its item
  for (genvar s = 0; s < PIPE_DEPTH; s++) begin : g_chk
    `PCTA_ASSERT_NXT(a_stall_keeps, valid_q[s] && !load[s], valid_q[s], "stalled item lost")
  end

  // an empty output stage lets the whole chain advance
  `PCTA_ASSERT_IMP(a_empty_ready, !out_valid_o, in_ready_o, "input blocked with output empty")

  // items in flight change only by accepts at either end
  `PCTA_ASSERT_IMP(a_occupancy, $past(rst_ni),
    $countones(valid_q) == $countones($past(valid_q)) + $past(in_acc) - $past(out_acc),
    "item count mismatch")

endmodule

// ===== sv/pixel_contrast_tint_adjust.sv =====
// Top level of the pixel contrast/tint adjust filter: config registers and pipeline.
// A pixel passes the front stage, the four divider stages and the output register.
// Throughput: one pixel per clock unless out_ready_i stalls; the divider stages (two
//   quotient bits each) and the v*k product path run in parallel, one item per stage.
// Reset: clears all stage valid bits and sets the filter to raise contrast, percent 0.
// Configuration is taken directly by the pipeline; write it only while idle.
module pixel_contrast_tint_adjust import pcta_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [CH_W-1:0]       blue_in_i,
  input  logic [CH_W-1:0]       green_in_i,
  input  logic [CH_W-1:0]       red_in_i,
  input  logic                  end_of_image_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [CH_W-1:0]       blue_out_o,
  output logic [CH_W-1:0]       green_out_o,
  output logic [CH_W-1:0]       red_out_o,
  output logic                  last_out_o
);

  logic [SEL_W-1:0] filter_q;
  logic [PCT_W-1:0] percent_q;
  logic [K_W-1:0]   k;
  chan_op_e         op_blue, op_green, op_red;
  stage_ctl_t       ctl;

  // register writes; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filter_q  <= FILT_RAISE;
      percent_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FILTER:  filter_q  <= cfg_wdata_i[SEL_W-1:0];
        CFG_PERCENT: percent_q <= cfg_wdata_i[PCT_W-1:0];
        default: ;
      endcase
    end
  end

  // strength factor scaled by 100: k = 100 + percent
  assign k = K_BASE + K_W'(percent_q);

  // per-channel operation; unused selector codes pass the pixel
  always_comb begin
    op_blue  = OP_PASS;
    op_green = OP_PASS;
    op_red   = OP_PASS;
    unique case (filter_q)
      FILT_RAISE: begin
        op_blue  = OP_RAISE;
        op_green = OP_RAISE;
        op_red   = OP_RAISE;
      end
      FILT_LOWER: begin
        op_blue  = OP_LOWER;
        op_green = OP_LOWER;
        op_red   = OP_LOWER;
      end
      FILT_TINT_BLUE:  op_blue  = OP_TINT;
      FILT_TINT_GREEN: op_green = OP_TINT;
      FILT_TINT_RED:   op_red   = OP_TINT;
      FILT_POSTER: begin
        op_blue  = OP_POSTER;
        op_green = OP_POSTER;
        op_red   = OP_POSTER;
      end
      default: ;
    endcase
  end

  // valid bits and stall enables; last-pixel flag rides along
  pcta_flow u_flow (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .last_i      (end_of_image_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .last_o      (last_out_o),
    .ctl_o       (ctl)
  );

  // one datapath lane per color channel, all stepped by the same enables
  pcta_chan u_blue (
    .clk_i (clk_i),
    .ctl_i (ctl),
    .op_i  (op_blue),
    .k_i   (k),
    .pix_i (blue_in_i),
    .pix_o (blue_out_o)
  );

  pcta_chan u_green (
    .clk_i (clk_i),
    .ctl_i (ctl),
    .op_i  (op_green),
    .k_i   (k),
    .pix_i (green_in_i),
    .pix_o (green_out_o)
  );

  pcta_chan u_red (
    .clk_i (clk_i),
    .ctl_i (ctl),
    .op_i  (op_red),
    .k_i   (k),
    .pix_i (red_in_i),
    .pix_o (red_out_o)
  );

endmodule
